@@ rtl/scgl_pkg.sv @@
// ----------------------------------------------------------------------------
// scgl_pkg
// Shared sizes, codes and control types of the segment glyph lookup unit.
// ----------------------------------------------------------------------------
package scgl_pkg;

    localparam int MAX_SEGMENTS      = 256;
    localparam int GLYPH_ARRAY_DEPTH = 1024;

    localparam int WORD_W   = 16;
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int SEGS_W   = 9;
    localparam int WORDS_W  = 11;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 11;

    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SEG_NW = SEG_AW + 1;
    localparam int GLY_AW = (GLYPH_ARRAY_DEPTH > 1) ? $clog2(GLYPH_ARRAY_DEPTH) : 1;
    localparam int GLY_NW = GLY_AW + 1;
    localparam int SEG_DW = 4 * WORD_W;
    localparam int IDX_W  = WORD_W + 2;

    localparam logic [MODE_W-1:0] MODE_SEG_WR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GLY_WR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_MAPPED   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNMAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_SEGMENTS = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_WORDS    = 1'd1;

    typedef struct packed {
        logic load;
        logic start;
        logic srch;
        logic seg;
        logic gly;
        logic out_load;
    } scgl_cmd_t;

    typedef struct packed {
        logic more;
        logic done_early;
        logic out_busy;
    } scgl_sts_t;

endpackage

@@ rtl/scgl_if.sv @@
// ----------------------------------------------------------------------------
// scgl_if
// Valid/ready channels for lookup requests and lookup responses.
// ----------------------------------------------------------------------------
interface scgl_req_if;
    import scgl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [SLOT_W-1:0]        slot;
    logic [WORD_W-1:0]        end_code;
    logic [WORD_W-1:0]        start_code;
    logic signed [WORD_W-1:0] delta;
    logic [WORD_W-1:0]        range_offset;
    logic [WORD_W-1:0]        glyph_word;
    logic [WORD_W-1:0]        char_code;

    modport source (
        output valid, mode, slot, end_code, start_code, delta, range_offset,
               glyph_word, char_code,
        input  ready
    );
    modport sink (
        input  valid, mode, slot, end_code, start_code, delta, range_offset,
               glyph_word, char_code,
        output ready
    );
endinterface

interface scgl_rsp_if;
    import scgl_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   glyph_id;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, glyph_id, status,
        input  ready
    );
    modport sink (
        input  valid, glyph_id, status,
        output ready
    );
endinterface

@@ rtl/scgl_ram.sv @@
// ----------------------------------------------------------------------------
// scgl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scgl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/scgl_ctrl.sv @@
// ----------------------------------------------------------------------------
// scgl_ctrl
// Sequencer for one lookup: search steps, segment check, glyph read, output.
// ----------------------------------------------------------------------------
module scgl_ctrl
    import scgl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      acc,
    input  logic      is_lookup,
    output logic      ready,
    output scgl_cmd_t cmd,
    input  scgl_sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SEG   = 3'd3;
    localparam logic [2:0] S_GLY   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc && is_lookup)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = sts.more ? S_SRCH : S_SEG;
            end
            S_SRCH:
            begin
                cmd.srch   = 1'b1;
                state_next = sts.more ? S_SRCH : S_SEG;
            end
            S_SEG:
            begin
                cmd.seg    = 1'b1;
                state_next = sts.done_early ? S_DONE : S_GLY;
            end
            S_GLY:
            begin
                cmd.gly    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register frees up
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ready = (state_reg == S_IDLE);

    a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
        acc && is_lookup |=> state_reg == S_START)
        else $error("lookup transfer did not start the search");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("output loaded while busy");

    a_gly_after_seg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GLY |-> $past(state_reg) == S_SEG)
        else $error("glyph read without segment check");

endmodule

@@ rtl/scgl_dp.sv @@
// ----------------------------------------------------------------------------
// scgl_dp
// Datapath: segment and glyph memories, search bounds, index math, output.
// ----------------------------------------------------------------------------
module scgl_dp
    import scgl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     acc,
    input  logic [MODE_W-1:0]        mode,
    input  logic [SLOT_W-1:0]        slot,
    input  logic [WORD_W-1:0]        end_code,
    input  logic [WORD_W-1:0]        start_code,
    input  logic signed [WORD_W-1:0] delta,
    input  logic [WORD_W-1:0]        range_offset,
    input  logic [WORD_W-1:0]        glyph_word,
    input  logic [WORD_W-1:0]        char_code,
    input  logic                     cfg_we,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data,
    input  scgl_cmd_t                cmd,
    output scgl_sts_t                sts,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [WORD_W-1:0]        out_glyph,
    output logic [STATUS_W-1:0]      out_status
);

    logic [SEGS_W-1:0]   segs_reg;
    logic [WORDS_W-1:0]  words_reg;
    logic [SEG_NW-1:0]   n_seg;
    logic [GLY_NW-1:0]   n_words;

    logic [WORD_W-1:0]   code_reg;
    logic [SEG_NW-1:0]   lo_reg;
    logic [SEG_NW-1:0]   hi_reg;
    logic [SEG_AW-1:0]   mid_reg;
    logic [WORD_W-1:0]   delta_reg;
    logic [WORD_W-1:0]   res_glyph_reg;
    logic [STATUS_W-1:0] res_status_reg;

    logic                out_valid_reg;
    logic [WORD_W-1:0]   out_glyph_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                seg_we;
    logic                gly_we;
    logic                seg_re;
    logic                gly_re;
    logic [SEG_AW-1:0]   seg_raddr;
    logic [SEG_DW-1:0]   seg_rdata;
    logic [WORD_W-1:0]   gly_rdata;
    logic [WORD_W-1:0]   rd_end;
    logic [WORD_W-1:0]   rd_start;
    logic [WORD_W-1:0]   rd_delta;
    logic [WORD_W-1:0]   rd_offset;

    logic                go_low;
    logic [SEG_NW-1:0]   lo_nx;
    logic [SEG_NW-1:0]   hi_nx;
    logic [SEG_NW-1:0]   lo_sel;
    logic [SEG_NW-1:0]   hi_sel;
    logic [SEG_NW:0]     mid_sum;
    logic [SEG_AW-1:0]   mid_sel;
    logic                more;

    logic                unmapped;
    logic                direct;
    logic [WORD_W-1:0]   code_diff;
    logic [IDX_W-1:0]    idx;
    logic                idx_bad;

    // configuration registers, saturated on use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segs_reg  <= SEGS_W'(1);
            words_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SEGMENTS)
            begin
                segs_reg <= cfg_data[SEGS_W-1:0];
            end
            if (cfg_index == CFG_WORDS)
            begin
                words_reg <= cfg_data[WORDS_W-1:0];
            end
        end
    end

    assign n_seg   = (32'(segs_reg) > 32'(MAX_SEGMENTS)) ? SEG_NW'(MAX_SEGMENTS)
                                                        : SEG_NW'(segs_reg);
    assign n_words = (32'(words_reg) > 32'(GLYPH_ARRAY_DEPTH)) ? GLY_NW'(GLYPH_ARRAY_DEPTH)
                                                              : GLY_NW'(words_reg);

    // table writes complete in the transfer cycle
    assign seg_we = acc && (mode == MODE_SEG_WR) && (32'(slot) < 32'(MAX_SEGMENTS));
    assign gly_we = acc && (mode == MODE_GLY_WR) && (32'(slot) < 32'(GLYPH_ARRAY_DEPTH));

    scgl_ram #(
        .WIDTH (SEG_DW),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (seg_we),
        .waddr (SEG_AW'(slot)),
        .wdata ({end_code, start_code, delta, range_offset}),
        .re    (seg_re),
        .raddr (seg_raddr),
        .rdata (seg_rdata)
    );

    scgl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (GLYPH_ARRAY_DEPTH)
    ) u_gly_ram (
        .clk   (clk),
        .we    (gly_we),
        .waddr (GLY_AW'(slot)),
        .wdata (glyph_word),
        .re    (gly_re),
        .raddr (idx[GLY_AW-1:0]),
        .rdata (gly_rdata)
    );

    assign {rd_end, rd_start, rd_delta, rd_offset} = seg_rdata;

    // one search step per cycle: narrow the bounds and fetch the next end code
    always_comb
    begin
        go_low  = (rd_end >= code_reg);
        lo_nx   = go_low ? lo_reg : ({1'b0, mid_reg} + SEG_NW'(1));
        hi_nx   = go_low ? {1'b0, mid_reg} : hi_reg;
        lo_sel  = cmd.srch ? lo_nx : lo_reg;
        hi_sel  = cmd.srch ? hi_nx : hi_reg;
        mid_sum = {1'b0, lo_sel} + {1'b0, hi_sel};
        mid_sel = mid_sum[SEG_AW:1];
        more    = (lo_sel < hi_sel);
    end

    // when the search ends, fetch the found segment (address wraps if none)
    assign seg_re    = cmd.start || cmd.srch;
    assign seg_raddr = more ? mid_sel : lo_sel[SEG_AW-1:0];

    always_comb
    begin
        unmapped  = (lo_reg >= n_seg) || (rd_start > code_reg);
        direct    = (rd_offset == '0);
        code_diff = code_reg - rd_start;
        idx       = {3'b000, rd_offset[WORD_W-1:1]} + {2'b00, code_diff}
                  - IDX_W'(n_seg - lo_reg);
        idx_bad   = idx[IDX_W-1] || (idx[IDX_W-2:0] >= (IDX_W-1)'(n_words));
    end

    assign gly_re = cmd.seg && !unmapped && !direct && !idx_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else if (cmd.load)
        begin
            lo_reg <= '0;
            hi_reg <= n_seg;
        end
        else if (cmd.srch)
        begin
            lo_reg <= lo_nx;
            hi_reg <= hi_nx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg <= char_code;
        end
        if (seg_re)
        begin
            mid_reg <= mid_sel;
        end
        if (cmd.seg)
        begin
            delta_reg <= rd_delta;
            if (unmapped)
            begin
                res_glyph_reg  <= '0;
                res_status_reg <= STAT_UNMAPPED;
            end
            else if (direct)
            begin
                res_glyph_reg  <= code_reg + rd_delta;
                res_status_reg <= STAT_MAPPED;
            end
            else
            begin
                res_glyph_reg  <= '0;
                res_status_reg <= STAT_RANGE;
            end
        end
        if (cmd.gly)
        begin
            res_glyph_reg  <= (gly_rdata != '0) ? (gly_rdata + delta_reg) : '0;
            res_status_reg <= STAT_MAPPED;
        end
        if (cmd.out_load)
        begin
            out_glyph_reg  <= res_glyph_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.more       = more;
    assign sts.done_early = unmapped || direct || idx_bad;
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_glyph  = out_glyph_reg;
    assign out_status = out_status_reg;

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search bounds crossed");

    a_zero_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != STAT_MAPPED) |-> out_glyph_reg == '0)
        else $error("nonzero glyph with failing status");

endmodule

@@ rtl/segment_char_to_glyph_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// segment_char_to_glyph_lookup_unit
// Segment table character-to-glyph lookup with binary search over end codes.
// ----------------------------------------------------------------------------
// Table writes (segment or glyph word) give no result. A lookup goes through a
// start step, up to log2(segments) + 1 search steps, the segment check, the glyph
// array read if one is needed and the output load, which waits while the output
// is busy. The single read port of the segment memory sets one search step per
// cycle. Reset clears the controller, output valid and the registers (segments
// 1, glyph words 0); the tables are not cleared and hold garbage until written.
module segment_char_to_glyph_lookup_unit
    import scgl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    scgl_req_if.sink          req,
    scgl_rsp_if.source        rsp
);

    scgl_cmd_t cmd;
    scgl_sts_t sts;
    logic      ready;
    logic      acc;

    assign req.ready = ready;
    assign acc       = req.valid && ready;

    scgl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .is_lookup (req.mode == MODE_LOOKUP),
        .ready     (ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    scgl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .mode         (req.mode),
        .slot         (req.slot),
        .end_code     (req.end_code),
        .start_code   (req.start_code),
        .delta        (req.delta),
        .range_offset (req.range_offset),
        .glyph_word   (req.glyph_word),
        .char_code    (req.char_code),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_glyph    (rsp.glyph_id),
        .out_status   (rsp.status)
    );

endmodule

@@ bench/scgl_glyph_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph lookup checker
// Watches the configuration port and both channels of the lookup unit. It
// keeps its own copy of the registers, segment table and glyph array, and
// works out the glyph and status of every lookup. Each response is compared
// with the oldest pending expectation.
// ----------------------------------------------------------------------------
module scgl_glyph_checker
    import scgl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    scgl_req_if               req_mon,
    scgl_rsp_if               rsp_mon,
    output int                outstanding,
    output int                mismatch_count
);

    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        logic [WORD_W-1:0]   glyph_id;
        logic [STATUS_W-1:0] status;
    } glyph_result_t;

    logic [SEGS_W-1:0]  segments_reg;
    logic [WORDS_W-1:0] words_reg;
    logic [WORD_W-1:0]  end_mem    [MAX_SEGMENTS];
    logic [WORD_W-1:0]  start_mem  [MAX_SEGMENTS];
    logic [WORD_W-1:0]  delta_mem  [MAX_SEGMENTS];
    logic [WORD_W-1:0]  offset_mem [MAX_SEGMENTS];
    logic [WORD_W-1:0]  glyph_mem  [GLYPH_ARRAY_DEPTH];

    glyph_result_t expected_glyphs [$];
    glyph_result_t oldest;

    initial
    begin
        outstanding    = 0;
        mismatch_count = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("[%0t] MISMATCH %s", $time, msg);
        end
    endtask

    function automatic glyph_result_t predict_glyph(input logic [WORD_W-1:0] code);
        int            n;
        int            words;
        int            lo;
        int            hi;
        int            mid;
        int            idx;
        glyph_result_t r;
        n     = (segments_reg > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(segments_reg);
        words = (words_reg > GLYPH_ARRAY_DEPTH) ? GLYPH_ARRAY_DEPTH : int'(words_reg);
        r.glyph_id = '0;
        r.status   = STAT_UNMAPPED;
        // first segment whose end code is at or above the code
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (end_mem[mid] >= code)
                hi = mid;
            else
                lo = mid + 1;
        end
        if (lo >= n || start_mem[lo] > code)
            return r;
        if (offset_mem[lo] == '0)
        begin
            r.glyph_id = code + delta_mem[lo];
            r.status   = STAT_MAPPED;
            return r;
        end
        idx = int'(offset_mem[lo] >> 1) + int'(code) - int'(start_mem[lo]) - (n - lo);
        if (idx < 0 || idx >= words)
        begin
            r.status = STAT_RANGE;
            return r;
        end
        r.status = STAT_MAPPED;
        // a zero word stays zero, no delta
        if (glyph_mem[idx] != '0)
            r.glyph_id = glyph_mem[idx] + delta_mem[lo];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            segments_reg = SEGS_W'(1);
            words_reg    = '0;
            expected_glyphs.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SEGMENTS: segments_reg = cfg_data[SEGS_W-1:0];
                    CFG_WORDS:    words_reg    = cfg_data[WORDS_W-1:0];
                    default:      ;
                endcase
            end

            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (expected_glyphs.size() == 0)
                begin
                    report_mismatch($sformatf("response with no lookup pending: glyph %h status %0d",
                                              rsp_mon.glyph_id, rsp_mon.status));
                end
                else
                begin
                    oldest = expected_glyphs.pop_front();
                    if (rsp_mon.glyph_id !== oldest.glyph_id)
                        report_mismatch($sformatf("glyph_id: got %h, expected %h",
                                                  rsp_mon.glyph_id, oldest.glyph_id));
                    if (rsp_mon.status !== oldest.status)
                        report_mismatch($sformatf("status: got %0d, expected %0d",
                                                  rsp_mon.status, oldest.status));
                end
            end

            if (req_mon.valid && req_mon.ready)
            begin
                case (req_mon.mode)
                    MODE_SEG_WR:
                    begin
                        if (req_mon.slot < MAX_SEGMENTS)
                        begin
                            end_mem[req_mon.slot]    = req_mon.end_code;
                            start_mem[req_mon.slot]  = req_mon.start_code;
                            delta_mem[req_mon.slot]  = req_mon.delta;
                            offset_mem[req_mon.slot] = req_mon.range_offset;
                        end
                    end
                    MODE_GLY_WR:
                    begin
                        if (req_mon.slot < GLYPH_ARRAY_DEPTH)
                            glyph_mem[req_mon.slot] = req_mon.glyph_word;
                    end
                    MODE_LOOKUP:
                    begin
                        expected_glyphs.push_back(predict_glyph(req_mon.char_code));
                    end
                    default: ;
                endcase
            end
        end
        outstanding = expected_glyphs.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment glyph lookup testbench
// Loads the low part of the glyph array once, runs a short directed set of
// lookups, then goes through several register settings, each with a fresh
// sorted segment table and a burst of mostly in-segment lookups mixed with
// table writes and ignored items, under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module tb
    import scgl_pkg::*;
();

    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    localparam int RUN_LIMIT_NS       = 5_000_000;
    localparam int SETTLE_CYCLES      = 20;
    localparam int LOOKUPS_PER_PHASE  = 68;
    localparam int PHASE_GLYPH_WRITES = 8;
    localparam int GLYPH_FILL         = 512;
    localparam int LONG_HOLD_CYCLES   = 400;
    localparam int PRESSURE_PHASE     = 2;
    localparam int PHASE_COUNT        = 8;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_kind_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] end_code;
        logic [WORD_W-1:0] start_code;
        logic [WORD_W-1:0] delta;
        logic [WORD_W-1:0] range_offset;
        logic [WORD_W-1:0] glyph_word;
        logic [WORD_W-1:0] char_code;
    } request_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    int outstanding;
    int mismatch_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit long_hold_req  = 1'b0;

    // segment bounds of the current table, used to aim lookups
    int tbl_start [MAX_SEGMENTS];
    int tbl_end   [MAX_SEGMENTS];
    int tbl_rows;

    scgl_req_if req_ch();
    scgl_rsp_if rsp_ch();

    segment_char_to_glyph_lookup_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    scgl_glyph_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_mon        (req_ch),
        .rsp_mon        (rsp_ch),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("Some tests failed");
        $finish;
    end

    // response side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic void set_idling(input idle_kind_t kind);
        send_idle_pct  = (kind == IDLE_SENDER)   ? 46 : (kind == IDLE_BOTH) ? 31 : 0;
        recv_stall_pct = (kind == IDLE_RECEIVER) ? 46 : (kind == IDLE_BOTH) ? 31 : 0;
    endfunction

    function automatic request_t random_request(input logic [MODE_W-1:0] mode);
        request_t r;
        r.mode         = mode;
        r.slot         = SLOT_W'($urandom);
        r.end_code     = WORD_W'($urandom);
        r.start_code   = WORD_W'($urandom);
        r.delta        = WORD_W'($urandom);
        r.range_offset = WORD_W'($urandom);
        r.glyph_word   = WORD_W'($urandom);
        r.char_code    = WORD_W'($urandom);
        return r;
    endfunction

    function automatic int random_glyph_word();
        return ($urandom_range(7) == 0) ? 0 : int'($urandom_range(65535, 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer,
    // with valid still high. The next call or wait_drained decides its level.
    task automatic push_request(input request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= r.mode;
        req_ch.slot         <= r.slot;
        req_ch.end_code     <= r.end_code;
        req_ch.start_code   <= r.start_code;
        req_ch.delta        <= r.delta;
        req_ch.range_offset <= r.range_offset;
        req_ch.glyph_word   <= r.glyph_word;
        req_ch.char_code    <= r.char_code;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_segment(input int slot, input int e, input int s, input int d,
                                input int roff);
        request_t r;
        r              = random_request(MODE_SEG_WR);
        r.slot         = SLOT_W'(slot);
        r.end_code     = WORD_W'(e);
        r.start_code   = WORD_W'(s);
        r.delta        = WORD_W'(d);
        r.range_offset = WORD_W'(roff);
        push_request(r);
    endtask

    task automatic send_glyph_word(input int slot, input int w);
        request_t r;
        r            = random_request(MODE_GLY_WR);
        r.slot       = SLOT_W'(slot);
        r.glyph_word = WORD_W'(w);
        push_request(r);
    endtask

    task automatic send_lookup(input int code);
        request_t r;
        r           = random_request(MODE_LOOKUP);
        r.char_code = WORD_W'(code);
        push_request(r);
    endtask

    task automatic send_ignored();
        push_request(random_request(MODE_IGNORED));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        // writes leave nothing to wait for, so give the block time to finish
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input int segs, input int words);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEGMENTS;
        cfg_data  <= CFG_DW'(segs);
        @(negedge clk);
        cfg_index <= CFG_WORDS;
        cfg_data  <= CFG_DW'(words);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Write rows 0..count-1 as a table sorted by end code. Most range offsets
    // point into the loaded glyph words.
    task automatic load_segment_table(input int count, input int words_eff);
        int step;
        int prev_end;
        int e;
        int s;
        int roff;
        int base;
        step     = 65536 / count;
        prev_end = -1;
        tbl_rows = count;
        for (int i = 0; i < count; i++)
        begin
            if (i == count - 1 && $urandom_range(1) == 1)
                e = 65535;
            else
                e = i * step + int'($urandom_range(step - 1, step / 2));
            if ($urandom_range(1) == 1)
                s = prev_end + 1;
            else
                s = int'($urandom_range(e, prev_end + 1));
            if ($urandom_range(2) == 0)
            begin
                roff = 0;
            end
            else
            begin
                base = int'($urandom_range((words_eff > 32) ? words_eff - 32 : 0));
                roff = 2 * (base + count - i) + int'($urandom_range(1));
                if ($urandom_range(15) == 0)
                    roff = int'($urandom_range(65535, 1));
            end
            send_segment(i, e, s, int'($urandom), roff);
            tbl_start[i] = s;
            tbl_end[i]   = e;
            prev_end     = e;
        end
    endtask

    initial
    begin
        int         segs_cfg  [PHASE_COUNT] = '{8, 64, 511, 0, 1, 37, 24, 3};
        int         words_cfg [PHASE_COUNT] = '{64, 512, 300, 512, 0, 300, 1, 450};
        idle_kind_t idle_cfg  [PHASE_COUNT] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                                IDLE_BOTH, IDLE_NONE, IDLE_BOTH,
                                                IDLE_SENDER, IDLE_RECEIVER};
        int         directed_codes [11]     = '{'h0000, 'h0005, 'h0010, 'h0050, 'h0080,
                                                'h0081, 'h0088, 'h7000, 'h7003, 'hfffe,
                                                'hffff};
        int         rows;
        int         words_eff;
        int         pick;
        int         row;
        int         span;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = '0;
        req_ch.slot         = '0;
        req_ch.end_code     = '0;
        req_ch.start_code   = '0;
        req_ch.delta        = '0;
        req_ch.range_offset = '0;
        req_ch.glyph_word   = '0;
        req_ch.char_code    = '0;
        set_idling(IDLE_NONE);
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill every glyph word that any word count below can reach; each
        // phase loads all the segment rows it searches.
        for (int i = 0; i < GLYPH_FILL; i++)
            send_glyph_word(i, random_glyph_word());

        send_segment(0, 'h0010, 'h0005, 'h7fff, 0);
        send_segment(1, 'h0100, 'h0080, 'hfffb, 6);
        send_segment(2, 'h8000, 'h7000, 'h0000, 3);
        send_segment(3, 'hfffe, 'hfff0, 'h8000, 0);
        send_segment(1023, 'hffff, 'hffff, 'hffff, 'hffff);
        send_glyph_word(0, 0);
        send_glyph_word(1, 3);
        send_glyph_word(2, 'hffff);
        // Directed: reset settings (one segment, empty glyph array) first.
        send_lookup(int'($urandom_range(65535)));
        send_ignored();
        wait_drained();
        write_config(4, 8);
        // below start, delta wrap, zero word, negative index, index past end,
        // code above every end
        foreach (directed_codes[i])
            send_lookup(directed_codes[i]);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_idling(idle_cfg[p]);
            if (segs_cfg[p] == 0)
                rows = 16;
            else
                rows = (segs_cfg[p] > MAX_SEGMENTS) ? MAX_SEGMENTS : segs_cfg[p];
            words_eff = (words_cfg[p] > GLYPH_ARRAY_DEPTH) ? GLYPH_ARRAY_DEPTH : words_cfg[p];
            load_segment_table(rows, words_eff);
            repeat (PHASE_GLYPH_WRITES)
                send_glyph_word(int'($urandom_range(GLYPH_ARRAY_DEPTH - 1)), random_glyph_word());
            wait_drained();
            write_config(segs_cfg[p], words_cfg[p]);
            if (p == PRESSURE_PHASE)
                long_hold_req = 1'b1;

            for (int k = 0; k < LOOKUPS_PER_PHASE; k++)
            begin
                pick = int'($urandom_range(99));
                row  = int'($urandom_range(tbl_rows - 1));
                span = tbl_end[row] - tbl_start[row];
                if (pick < 50)
                begin
                    send_lookup(tbl_start[row] + int'($urandom_range((span < 48) ? span : 48)));
                end
                else if (pick < 65)
                begin
                    send_lookup(int'($urandom_range(tbl_end[row], tbl_start[row])));
                end
                else if (pick < 75)
                begin
                    case ($urandom_range(2))
                        0:       send_lookup(tbl_end[row]);
                        1:       send_lookup(tbl_end[row] + 1);
                        default: send_lookup(tbl_start[row] - 1);
                    endcase
                end
                else if (pick < 85)
                begin
                    send_lookup(int'($urandom_range(65535)));
                end
                else if (pick < 91)
                begin
                    send_glyph_word(int'($urandom_range(GLYPH_ARRAY_DEPTH - 1)),
                                    random_glyph_word());
                end
                else if (pick < 95)
                begin
                    // rows past the table are either unused or dropped by the block
                    send_segment(int'($urandom_range(1023, tbl_rows)), int'($urandom),
                                 int'($urandom), int'($urandom), int'($urandom));
                end
                else if (pick < 97)
                begin
                    // scramble a live row; the search stays defined on an unsorted table
                    send_segment(row, int'($urandom), int'($urandom), int'($urandom),
                                 int'($urandom));
                end
                else
                begin
                    send_ignored();
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/scgl_pkg.sv
rtl/scgl_if.sv
rtl/scgl_ram.sv
rtl/scgl_ctrl.sv
rtl/scgl_dp.sv
rtl/segment_char_to_glyph_lookup_unit.sv
bench/scgl_glyph_checker.sv
bench/tb.sv
